>>> sv/cron_expression_parse_match_top_assert.svh
// Assertion macros for the cron matcher top level.
`ifndef CRON_EXPRESSION_PARSE_MATCH_TOP_ASSERT_SVH
`define CRON_EXPRESSION_PARSE_MATCH_TOP_ASSERT_SVH

// Implication in the same cycle.
`define CEP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication in the next cycle.
`define CEP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/cep_pkg.sv
package cep_pkg;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FEW      = 3'd1;
    localparam logic [2:0] ST_MALFORM  = 3'd2;
    localparam logic [2:0] ST_STEP     = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;
    localparam logic [2:0] ST_VALUE    = 3'd5;
    localparam logic [2:0] ST_EMPTY    = 3'd6;

    localparam int MIN_W  = 60;
    localparam int HOUR_W = 24;
    localparam int DAY_W  = 31;
    localparam int MON_W  = 12;
    localparam int WDAY_W = 7;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic begin_expr;
        logic chr;
        logic eval;
        logic fill;
        logic empty;
        logic fin_chk;
        logic finish;
        logic load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_check;
        logic phase_start;
        logic phase_field;
        logic close_req;
        logic field_end;
        logic final_char;
        logic fill_go;
        logic fill_last;
        logic out_free;
    } stat_t;

endpackage

>>> sv/cep_ifs.sv
interface cep_in_if;
    import cep_pkg::*;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] char_code;
    logic       final_char;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [2:0] weekday;

    modport source (output valid, func, char_code, final_char, minute, hour, day, month,
                    weekday, input ready);
    modport sink (input valid, func, char_code, final_char, minute, hour, day, month,
                  weekday, output ready);
endinterface

interface cep_out_if;
    import cep_pkg::*;
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic              parse_done;
    logic              matched;
    logic [MIN_W-1:0]  minute_bits;
    logic [HOUR_W-1:0] hour_bits;
    logic [DAY_W-1:0]  day_bits;
    logic [MON_W-1:0]  month_bits;
    logic [WDAY_W-1:0] weekday_bits;

    modport source (output valid, status, parse_done, matched, minute_bits, hour_bits,
                    day_bits, month_bits, weekday_bits, input ready);
    modport sink (input valid, status, parse_done, matched, minute_bits, hour_bits,
                  day_bits, month_bits, weekday_bits, output ready);
endinterface

>>> sv/cron_expression_parse_match_top.sv
// Five-field cron expression parser and time matcher. Send an expression one
// character per request (func 0, last character flagged by final_char); the
// last character returns one result with parse_done 1, the error code (too
// few fields wins, else the first in field order) and the five selection
// sets. A request with func 1 checks the given time and returns matched,
// which is 1 only when the stored expression is valid and every field
// selects the time. A comma or a field-ending blank evaluates its segment,
// and the single-bit span fill loop then sets the values it selects one at
// a time (up to 60); a field-ending blank also checks for an empty field.
// A final character that ends a field runs the same steps for its last
// segment before the expression is finished. A result waits in the output
// register until taken; a new result cannot load while the previous one
// waits. One request is handled at a time; the result register lets a new
// request be taken while a finished result waits.
module cron_expression_parse_match_top
    import cep_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    cep_in_if.sink    in_ch,
    cep_out_if.source out_ch
);

`include "cron_expression_parse_match_top_assert.svh"

    cmd_t  cmd;
    stat_t stat;
    logic  ctrl_ready;

    // sequencer: one request at a time, span fill as an iterated loop
    cep_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (ctrl_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // lexer, number parsers, field sets and result register
    cep_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // input is taken only while the sequencer is idle
    assign in_ch.ready = ctrl_ready;

    // Assertions
    `CEP_ASSERT_NEXT(a_one_at_a_time, in_ch.valid && in_ch.ready, !in_ch.ready,
        "second request taken while busy")
    `CEP_ASSERT_NOW(a_load_free, cmd.load, !out_ch.valid || out_ch.ready,
        "result overwritten before taken")
    `CEP_ASSERT_NOW(a_match_ok, out_ch.valid && !out_ch.parse_done && out_ch.matched,
        out_ch.status == ST_OK, "match reported with bad expression")
    `CEP_ASSERT_NOW(a_fail_clear, out_ch.valid && out_ch.parse_done && out_ch.status != ST_OK,
        out_ch.minute_bits == '0, "failed parse left sets")

endmodule

>>> sv/cep_ctrl.sv
module cep_ctrl
    import cep_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_DECODE = 10'b00_0000_0010,
        S_CHAR   = 10'b00_0000_0100,
        S_EVAL   = 10'b00_0000_1000,
        S_FILL   = 10'b00_0001_0000,
        S_AFTER  = 10'b00_0010_0000,
        S_EMPTY  = 10'b00_0100_0000,
        S_FINCHK = 10'b00_1000_0000,
        S_FINISH = 10'b01_0000_0000,
        S_EMIT   = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                if (stat.is_check)
                    state_next = S_EMIT;
                else
                begin
                    cmd.begin_expr = stat.phase_start;
                    state_next = S_CHAR;
                end
            end
            S_CHAR:
            begin
                cmd.chr = 1'b1;
                if (stat.close_req)
                    state_next = S_EVAL;
                else if (stat.final_char)
                    state_next = S_FINCHK;
                else
                    state_next = S_IDLE;
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                state_next = stat.fill_go ? S_FILL : S_AFTER;
            end
            S_FILL:
            begin
                cmd.fill = 1'b1;
                if (stat.fill_last)
                    state_next = S_AFTER;
            end
            S_AFTER:
            begin
                if (stat.field_end)
                    state_next = S_EMPTY;
                else if (stat.final_char)
                    state_next = S_FINCHK;
                else
                    state_next = S_IDLE;
            end
            S_EMPTY:
            begin
                cmd.empty = 1'b1;
                state_next = stat.final_char ? S_FINCHK : S_IDLE;
            end
            S_FINCHK:
            begin
                cmd.fin_chk = 1'b1;
                state_next = stat.phase_field ? S_EVAL : S_FINISH;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> sv/cep_dp.sv
module cep_dp
    import cep_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    output stat_t stat,
    cep_in_if.sink    in_ch,
    cep_out_if.source out_ch
);

    typedef enum logic [2:0] {
        PH_START = 3'b001,
        PH_SPACE = 3'b010,
        PH_FIELD = 3'b100
    } phase_t;

    typedef struct packed {
        logic        started;
        logic        digits;
        logic        neg;
        logic        bad;
        logic [31:0] mag;
    } num_t;

    localparam logic [35:0] NUM_CAP = 36'h0_8000_0001;

    function automatic num_t num_feed(input num_t n, input logic [7:0] c);
        num_t        r;
        logic [35:0] m;
        begin
            r = n;
            m = {1'b0, n.mag, 3'b000} + {3'b000, n.mag, 1'b0} + {32'd0, c[3:0] - 4'd0};
            if (!n.started && c == "-")
                r.neg = 1'b1;
            else if (c >= "0" && c <= "9")
            begin
                r.digits = 1'b1;
                r.mag = (m > NUM_CAP) ? NUM_CAP[31:0] : m[31:0];
            end
            else
                r.bad = 1'b1;
            r.started = 1'b1;
            return r;
        end
    endfunction

    function automatic logic num_ok(input num_t n);
        return !n.bad && n.digits && (n.neg ? (n.mag <= 32'h8000_0000)
                                            : (n.mag <= 32'h7FFF_FFFF));
    endfunction

    function automatic logic num_in(input num_t n, input logic lo, input logic [5:0] hi);
        return (!n.neg || n.mag == 32'd0) && (n.mag <= {26'd0, hi}) && (n.mag >= {31'd0, lo});
    endfunction

    function automatic logic fld_lo(input logic [2:0] f);
        return (f == 3'd2) || (f == 3'd3);
    endfunction

    function automatic logic [5:0] fld_hi(input logic [2:0] f);
        logic [5:0] h;
        begin
            case (f)
                3'd0:    h = 6'd59;
                3'd1:    h = 6'd23;
                3'd2:    h = 6'd31;
                3'd3:    h = 6'd12;
                default: h = 6'd6;
            endcase
            return h;
        end
    endfunction

    function automatic logic [3:0] mac_len(input logic [1:0] k);
        logic [3:0] l;
        begin
            case (k)
                2'd0:    l = 4'd7;
                2'd1:    l = 4'd6;
                2'd2:    l = 4'd7;
                default: l = 4'd8;
            endcase
            return l;
        end
    endfunction

    function automatic logic [7:0] mac_char(input logic [1:0] k, input logic [2:0] i);
        logic [63:0] t;
        begin
            case (k)
                2'd0:    t = {"@hourly", 8'h00};
                2'd1:    t = {"@daily", 16'h0000};
                2'd2:    t = {"@weekly", 8'h00};
                default: t = "@monthly";
            endcase
            return t[{3'd7 - i, 3'b000} +: 8];
        end
    endfunction

    // captured item
    logic       func_reg, final_reg;
    logic [7:0] c_reg;
    logic [5:0] mi_reg;
    logic [4:0] hr_reg, dy_reg;
    logic [3:0] mo_reg;
    logic [2:0] wd_reg;

    // lexer / expression state
    phase_t            phase_reg;
    logic [2:0]        fi_reg, ferr_reg;
    logic [3:0]        fc_reg, mt_reg;
    logic              ev_reg, fend_reg;
    logic [MIN_W-1:0]  mset_reg;
    logic [HOUR_W-1:0] hset_reg;
    logic [DAY_W-1:0]  dset_reg;
    logic [MON_W-1:0]  moset_reg;
    logic [WDAY_W-1:0] wset_reg;

    // segment
    logic       snz_reg, step_reg, dash_reg, star_reg;
    logic [1:0] blen_reg;
    num_t       ln_reg, rn_reg, sn_reg;

    // span fill
    logic [5:0]  v_reg, b_reg;
    logic [30:0] st_reg;

    // result
    logic              ov_reg, opd_reg, omt_reg;
    logic [2:0]        ost_reg;
    logic [MIN_W-1:0]  om_reg;
    logic [HOUR_W-1:0] oh_reg;
    logic [DAY_W-1:0]  od_reg;
    logic [MON_W-1:0]  omo_reg;
    logic [WDAY_W-1:0] ow_reg;

    logic [7:0] c_fold;
    logic       ws;
    assign c_fold = (in_ch.char_code >= "A" && in_ch.char_code <= "Z")
                  ? in_ch.char_code + 8'd32 : in_ch.char_code;
    assign ws = (c_reg == " ") || (c_reg >= 8'd9 && c_reg <= 8'd13);

    // segment evaluation
    logic [2:0]  f;
    logic        lo, f_ok, okl, okr, oks, inl, inr, stpos, star, do_eval;
    logic [5:0]  hi, hi_i, a_i, b_i, lv, rv;
    logic [30:0] st;
    logic [2:0]  e_code;
    logic [31:0] v_sum;
    logic        set_zero;

    assign f     = fi_reg - 3'd1;
    assign f_ok  = (fi_reg != 3'd0) && (fi_reg <= 3'd5);
    assign lo    = fld_lo(f);
    assign hi    = fld_hi(f);
    assign hi_i  = hi - {5'd0, lo};
    assign okl   = num_ok(ln_reg);
    assign okr   = num_ok(rn_reg);
    assign oks   = num_ok(sn_reg);
    assign inl   = num_in(ln_reg, lo, hi);
    assign inr   = num_in(rn_reg, lo, hi);
    assign lv    = ln_reg.mag[5:0] - {5'd0, lo};
    assign rv    = rn_reg.mag[5:0] - {5'd0, lo};
    assign stpos = !sn_reg.neg && (sn_reg.mag != 32'd0);
    assign star  = (blen_reg == 2'd1) && star_reg;
    assign do_eval = snz_reg && f_ok && (ferr_reg == ST_OK);

    always_comb
    begin
        e_code = ST_OK;
        a_i = lv;
        b_i = lv;
        st = 31'd1;
        if (!step_reg)
        begin
            if (star)
            begin
                a_i = 6'd0;
                b_i = hi_i;
            end
            else if (dash_reg)
            begin
                b_i = rv;
                if (!okl || !okr)
                    e_code = ST_MALFORM;
                else if (!(inl && inr && lv <= rv))
                    e_code = ST_RANGE;
            end
            else if (!okl)
                e_code = ST_MALFORM;
            else if (!inl)
                e_code = ST_VALUE;
        end
        else
        begin
            st = sn_reg.mag[30:0];
            if (!oks)
                e_code = ST_MALFORM;
            else if (star || blen_reg == 2'd0)
            begin
                a_i = 6'd0;
                b_i = hi_i;
                if (!stpos)
                    e_code = ST_STEP;
            end
            else if (dash_reg)
            begin
                b_i = rv;
                if (!okl || !okr)
                    e_code = ST_MALFORM;
                else if (!stpos)
                    e_code = ST_STEP;
                else if (!(inl && inr && lv <= rv))
                    e_code = ST_RANGE;
            end
            else
            begin
                b_i = hi_i;
                if (!okl)
                    e_code = ST_MALFORM;
                else if (!stpos)
                    e_code = ST_STEP;
                else if (!inl)
                    e_code = ST_RANGE;
            end
        end
    end

    assign v_sum = {26'd0, v_reg} + {1'b0, st_reg};

    always_comb
    begin
        case (f)
            3'd0:    set_zero = (mset_reg == '0);
            3'd1:    set_zero = (hset_reg == '0);
            3'd2:    set_zero = (dset_reg == '0);
            3'd3:    set_zero = (moset_reg == '0);
            default: set_zero = (wset_reg == '0);
        endcase
    end

    // macro match at the end of the expression
    logic       mac_hit;
    logic [1:0] mac_k;
    always_comb
    begin
        mac_hit = 1'b0;
        mac_k = 2'd0;
        for (int k = 3; k >= 0; k--)
        begin
            if (fi_reg == 3'd1 && mt_reg[k] && fc_reg == mac_len(2'(k)))
            begin
                mac_hit = 1'b1;
                mac_k = 2'(k);
            end
        end
    end

    // character-step effective field bookkeeping
    logic       new_fld;
    logic [2:0] fi_eff;
    logic [3:0] fc_eff, mt_eff, mt_upd;
    assign new_fld = (phase_reg != PH_FIELD);
    assign fi_eff  = (new_fld && fi_reg != 3'd7) ? fi_reg + 3'd1 : fi_reg;
    assign fc_eff  = new_fld ? 4'd0 : fc_reg;
    assign mt_eff  = (new_fld && fi_eff == 3'd1) ? 4'hF : mt_reg;

    always_comb
    begin
        mt_upd = mt_eff;
        if (fi_eff == 3'd1)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (mt_eff[k] && (fc_eff >= mac_len(2'(k))
                                  || mac_char(2'(k), fc_eff[2:0]) != c_reg))
                    mt_upd[k] = 1'b0;
            end
        end
    end

    logic time_hit;
    assign time_hit = ev_reg
        && mi_reg < 6'd60 && mset_reg[mi_reg]
        && hr_reg < 5'd24 && hset_reg[hr_reg]
        && dy_reg >= 5'd1 && dset_reg[dy_reg - 5'd1]
        && mo_reg >= 4'd1 && mo_reg <= 4'd12 && moset_reg[mo_reg - 4'd1]
        && wd_reg < 3'd7 && wset_reg[wd_reg];

    assign stat.is_check   = func_reg;
    assign stat.phase_start = (phase_reg == PH_START);
    assign stat.phase_field = (phase_reg == PH_FIELD);
    assign stat.close_req  = ws ? (phase_reg == PH_FIELD) : (c_reg == ",");
    assign stat.field_end  = fend_reg;
    assign stat.final_char = final_reg;
    assign stat.fill_go    = do_eval && (e_code == ST_OK);
    assign stat.fill_last  = v_sum > {26'd0, b_reg};
    assign stat.out_free   = !ov_reg || out_ch.ready;

    // payload-only captures
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            c_reg  <= c_fold;
            mi_reg <= in_ch.minute;
            hr_reg <= in_ch.hour;
            dy_reg <= in_ch.day;
            mo_reg <= in_ch.month;
            wd_reg <= in_ch.weekday;
        end
        if (cmd.eval && stat.fill_go)
        begin
            v_reg  <= a_i;
            b_reg  <= b_i;
            st_reg <= st;
        end
        else if (cmd.fill)
            v_reg <= v_sum[5:0];
        if (cmd.load)
        begin
            opd_reg <= !func_reg;
            omt_reg <= func_reg && time_hit;
            ost_reg <= ferr_reg;
            om_reg  <= mset_reg;
            oh_reg  <= hset_reg;
            od_reg  <= dset_reg;
            omo_reg <= moset_reg;
            ow_reg  <= wset_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            func_reg <= 1'b0;
            final_reg <= 1'b0;
            phase_reg <= PH_START;
            fi_reg <= 3'd0;
            ferr_reg <= ST_OK;
            fc_reg <= 4'd0;
            mt_reg <= 4'd0;
            ev_reg <= 1'b0;
            fend_reg <= 1'b0;
            mset_reg <= '0;
            hset_reg <= '0;
            dset_reg <= '0;
            moset_reg <= '0;
            wset_reg <= '0;
            snz_reg <= 1'b0;
            step_reg <= 1'b0;
            dash_reg <= 1'b0;
            star_reg <= 1'b0;
            blen_reg <= 2'd0;
            ln_reg <= '0;
            rn_reg <= '0;
            sn_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                func_reg <= in_ch.func;
                final_reg <= in_ch.final_char;
            end
            if (cmd.begin_expr)
            begin
                mset_reg <= '0;
                hset_reg <= '0;
                dset_reg <= '0;
                moset_reg <= '0;
                wset_reg <= '0;
                ev_reg <= 1'b0;
                fi_reg <= 3'd0;
                ferr_reg <= ST_OK;
                mt_reg <= 4'd0;
                fc_reg <= 4'd0;
                phase_reg <= PH_SPACE;
            end
            if (cmd.chr)
            begin
                if (ws)
                begin
                    if (phase_reg == PH_FIELD)
                    begin
                        fend_reg <= 1'b1;
                        phase_reg <= PH_SPACE;
                    end
                end
                else
                begin
                    phase_reg <= PH_FIELD;
                    fi_reg <= fi_eff;
                    mt_reg <= mt_upd;
                    fc_reg <= (fc_eff < 4'd15) ? fc_eff + 4'd1 : fc_eff;
                    if (c_reg != ",")
                    begin
                        snz_reg <= 1'b1;
                        if (step_reg)
                            sn_reg <= num_feed(sn_reg, c_reg);
                        else if (c_reg == "/")
                            step_reg <= 1'b1;
                        else
                        begin
                            if (blen_reg != 2'd2)
                                blen_reg <= blen_reg + 2'd1;
                            if (blen_reg == 2'd0 && c_reg == "*")
                                star_reg <= 1'b1;
                            if (!dash_reg && c_reg == "-")
                                dash_reg <= 1'b1;
                            else if (dash_reg)
                                rn_reg <= num_feed(rn_reg, c_reg);
                            else
                                ln_reg <= num_feed(ln_reg, c_reg);
                        end
                    end
                end
            end
            if (cmd.eval)
            begin
                if (do_eval && e_code != ST_OK)
                    ferr_reg <= e_code;
                snz_reg <= 1'b0;
                step_reg <= 1'b0;
                dash_reg <= 1'b0;
                star_reg <= 1'b0;
                blen_reg <= 2'd0;
                ln_reg <= '0;
                rn_reg <= '0;
                sn_reg <= '0;
            end
            if (cmd.fill)
            begin
                case (f)
                    3'd0:    mset_reg[v_reg] <= 1'b1;
                    3'd1:    hset_reg[v_reg[4:0]] <= 1'b1;
                    3'd2:    dset_reg[v_reg[4:0]] <= 1'b1;
                    3'd3:    moset_reg[v_reg[3:0]] <= 1'b1;
                    default: wset_reg[v_reg[2:0]] <= 1'b1;
                endcase
            end
            if (cmd.empty)
            begin
                fend_reg <= 1'b0;
                if (f_ok && ferr_reg == ST_OK && set_zero)
                    ferr_reg <= ST_EMPTY;
            end
            if (cmd.fin_chk && phase_reg == PH_FIELD)
            begin
                fend_reg <= 1'b1;
                phase_reg <= PH_SPACE;
            end
            if (cmd.finish)
            begin
                phase_reg <= PH_START;
                if (mac_hit)
                begin
                    mset_reg <= 60'd1;
                    hset_reg <= (mac_k == 2'd0) ? '1 : 24'd1;
                    dset_reg <= (mac_k == 2'd3) ? 31'd1 : '1;
                    moset_reg <= '1;
                    wset_reg <= (mac_k == 2'd2) ? 7'd1 : '1;
                    ferr_reg <= ST_OK;
                    ev_reg <= 1'b1;
                end
                else if (fi_reg < 3'd5 || ferr_reg != ST_OK)
                begin
                    mset_reg <= '0;
                    hset_reg <= '0;
                    dset_reg <= '0;
                    moset_reg <= '0;
                    wset_reg <= '0;
                    ev_reg <= 1'b0;
                    ferr_reg <= (fi_reg < 3'd5) ? ST_FEW : ferr_reg;
                end
                else
                    ev_reg <= 1'b1;
            end
            if (cmd.load)
                ov_reg <= 1'b1;
            else if (out_ch.ready)
                ov_reg <= 1'b0;
        end
    end

    assign out_ch.valid        = ov_reg;
    assign out_ch.status       = ost_reg;
    assign out_ch.parse_done   = opd_reg;
    assign out_ch.matched      = omt_reg;
    assign out_ch.minute_bits  = om_reg;
    assign out_ch.hour_bits    = oh_reg;
    assign out_ch.day_bits     = od_reg;
    assign out_ch.month_bits   = omo_reg;
    assign out_ch.weekday_bits = ow_reg;

endmodule

>>> tb/cep_tb_ifs.sv
`timescale 1ns / 1ps
// (interfaces come from the RTL's cep_ifs.sv; this file holds the request record)
package cep_tb_pkg;
    typedef struct {
        logic       func;
        logic [7:0] char_code;
        logic       final_char;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [2:0] weekday;
    } cron_req_t;

    typedef struct {
        logic [2:0]  status;
        logic        parse_done;
        logic        matched;
        logic [59:0] minute_bits;
        logic [23:0] hour_bits;
        logic [30:0] day_bits;
        logic [11:0] month_bits;
        logic [6:0]  weekday_bits;
    } cron_res_t;
endpackage

>>> tb/cron_expression_parse_match_top_tb.sv
`timescale 1ns / 1ps
module cron_expression_parse_match_top_tb;
    import cep_pkg::*;
    import cep_tb_pkg::*;

    logic clk;
    logic rst_n;
    int   errors;
    int   cycle_cnt;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_off;          // long receiver stall, counted down in its own process
    cron_res_t expected_q[$];

    cep_in_if  in_ch();
    cep_out_if out_ch();

    cron_expression_parse_match_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit: ends the run with TB_ERROR once the cycle counter passes its limit.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 900000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor state: mirrors the parser/lexer of the block
    // ------------------------------------------------------------------
    typedef struct {
        bit         started;
        bit         digits;
        bit         neg;
        bit         bad;
        longint     mag;
    } num_acc_t;

    localparam int PH_START = 0;
    localparam int PH_SPACE = 1;
    localparam int PH_FIELD = 2;

    logic [63:0] set_bits[5];
    bit          valid_expr;
    int          fld_cnt;
    int          lex_ph;
    logic [2:0]  err_code;
    logic [3:0]  macro_live;
    int          fld_chars;
    int          seg_chars;
    int          base_chars;
    bit          stepping;
    bit          has_dash;
    bit          star_first;
    num_acc_t    lhs_num, rhs_num, step_acc;

    function automatic longint fld_low(int f);
        return (f == 2 || f == 3) ? 1 : 0;
    endfunction

    function automatic longint fld_high(int f);
        case (f)
            0: return 59;
            1: return 23;
            2: return 31;
            3: return 12;
            default: return 6;
        endcase
    endfunction

    function automatic string macro_str(int k);
        case (k)
            0: return "@hourly";
            1: return "@daily";
            2: return "@weekly";
            default: return "@monthly";
        endcase
    endfunction

    function automatic void num_clear(ref num_acc_t n);
        n.started = 0; n.digits = 0; n.neg = 0; n.bad = 0; n.mag = 0;
    endfunction

    function automatic void num_push(ref num_acc_t n, input int c);
        if (!n.started && c == "-")
            n.neg = 1;
        else if (c >= "0" && c <= "9")
        begin
            n.digits = 1;
            n.mag = n.mag * 10 + (c - "0");
            if (n.mag > 64'h80000001)
                n.mag = 64'h80000001;
        end
        else
            n.bad = 1;
        n.started = 1;
    endfunction

    function automatic bit num_value(input num_acc_t n, output longint v);
        longint lim;
        lim = n.neg ? 64'h80000000 : 64'h7FFFFFFF;
        v = 0;
        if (n.bad || !n.digits || n.mag > lim)
            return 0;
        v = n.neg ? -n.mag : n.mag;
        return 1;
    endfunction

    function automatic void seg_reset();
        seg_chars = 0; base_chars = 0;
        stepping = 0; has_dash = 0; star_first = 0;
        num_clear(lhs_num); num_clear(rhs_num); num_clear(step_acc);
    endfunction

    function automatic logic [2:0] fill_span(int f, longint a, longint b, longint st);
        longint v;
        if (st <= 0)
            return ST_STEP;
        if (a > b || a < fld_low(f) || b > fld_high(f))
            return ST_RANGE;
        for (v = a; v <= b; v += st)
            set_bits[f][v - fld_low(f)] = 1'b1;
        return ST_OK;
    endfunction

    function automatic logic [2:0] seg_eval(int f);
        longint a, b, st, lo, hi;
        bit     star;
        lo = fld_low(f);
        hi = fld_high(f);
        star = (base_chars == 1) && star_first;
        if (!stepping)
        begin
            if (star)
                return fill_span(f, lo, hi, 1);
            if (has_dash)
            begin
                if (!num_value(lhs_num, a) || !num_value(rhs_num, b))
                    return ST_MALFORM;
                return fill_span(f, a, b, 1);
            end
            if (!num_value(lhs_num, a))
                return ST_MALFORM;
            if (a < lo || a > hi)
                return ST_VALUE;
            set_bits[f][a - lo] = 1'b1;
            return ST_OK;
        end
        if (!num_value(step_acc, st))
            return ST_MALFORM;
        if (star || base_chars == 0)
        begin
            a = lo; b = hi;
        end
        else if (has_dash)
        begin
            if (!num_value(lhs_num, a) || !num_value(rhs_num, b))
                return ST_MALFORM;
        end
        else
        begin
            if (!num_value(lhs_num, a))
                return ST_MALFORM;
            b = hi;
        end
        return fill_span(f, a, b, st);
    endfunction

    function automatic void seg_close();
        int f;
        f = fld_cnt - 1;
        if (seg_chars != 0 && f >= 0 && f < 5 && err_code == ST_OK)
            err_code = seg_eval(f);
        seg_reset();
    endfunction

    function automatic void field_close();
        int f;
        f = fld_cnt - 1;
        seg_close();
        if (f >= 0 && f < 5 && err_code == ST_OK && set_bits[f] == 0)
            err_code = ST_EMPTY;
    endfunction

    function automatic void field_push(int c);
        string m;
        for (int k = 0; k < 4; k++)
        begin
            m = macro_str(k);
            if (fld_cnt == 1 && macro_live[k])
                if (fld_chars >= m.len() || m[fld_chars] != c)
                    macro_live[k] = 1'b0;
        end
        if (fld_chars < 15)
            fld_chars++;
        if (c == ",")
        begin
            seg_close();
            return;
        end
        if (seg_chars < 255)
            seg_chars++;
        if (stepping)
        begin
            num_push(step_acc, c);
            return;
        end
        if (c == "/")
        begin
            stepping = 1;
            return;
        end
        if (base_chars < 255)
            base_chars++;
        if (base_chars == 1 && c == "*")
            star_first = 1;
        if (!has_dash && c == "-")
            has_dash = 1;
        else if (has_dash)
            num_push(rhs_num, c);
        else
            num_push(lhs_num, c);
    endfunction

    function automatic void expr_begin();
        for (int f = 0; f < 5; f++)
            set_bits[f] = '0;
        valid_expr = 0; fld_cnt = 0; err_code = ST_OK; macro_live = '0; fld_chars = 0;
        seg_reset();
    endfunction

    function automatic logic [2:0] expr_finish();
        int         hit_k;
        logic [2:0] st;
        string      m;
        hit_k = -1;
        for (int k = 0; k < 4; k++)
        begin
            m = macro_str(k);
            if (hit_k < 0 && fld_cnt == 1 && macro_live[k] && fld_chars == m.len())
                hit_k = k;
        end
        if (hit_k >= 0)
        begin
            set_bits[0] = 1;
            set_bits[1] = (hit_k == 0) ? 64'hFFFFFF : 1;
            set_bits[2] = (hit_k == 3) ? 1 : 64'h7FFFFFFF;
            set_bits[3] = 64'hFFF;
            set_bits[4] = (hit_k == 2) ? 1 : 64'h7F;
            st = ST_OK;
        end
        else if (fld_cnt < 5)
            st = ST_FEW;
        else
            st = err_code;
        if (st != ST_OK)
        begin
            for (int f = 0; f < 5; f++)
                set_bits[f] = '0;
            valid_expr = 0;
        end
        else
            valid_expr = 1;
        err_code = st;
        return st;
    endfunction

    function automatic cron_res_t snapshot(logic [2:0] st, bit done, bit hit);
        cron_res_t r;
        r.status       = st;
        r.parse_done   = done;
        r.matched      = hit;
        r.minute_bits  = set_bits[0][59:0];
        r.hour_bits    = set_bits[1][23:0];
        r.day_bits     = set_bits[2][30:0];
        r.month_bits   = set_bits[3][11:0];
        r.weekday_bits = set_bits[4][6:0];
        return r;
    endfunction

    // Advance the predictor by one accepted request; queue a result if one is due.
    function automatic void cron_predict(cron_req_t q);
        int         c;
        bit         ws, hit;
        logic [2:0] st;
        if (q.func)
        begin
            hit = valid_expr
                && q.minute < 60 && set_bits[0][q.minute]
                && q.hour < 24 && set_bits[1][q.hour]
                && q.day >= 1 && set_bits[2][q.day - 1]
                && q.month >= 1 && q.month <= 12 && set_bits[3][q.month - 1]
                && q.weekday < 7 && set_bits[4][q.weekday];
            expected_q.push_back(snapshot(err_code, 0, hit));
            return;
        end
        c = q.char_code;
        if (lex_ph == PH_START)
        begin
            expr_begin();
            lex_ph = PH_SPACE;
        end
        if (c >= "A" && c <= "Z")
            c += 32;
        ws = (c == " ") || (c >= 9 && c <= 13);
        if (ws)
        begin
            if (lex_ph == PH_FIELD)
            begin
                field_close();
                lex_ph = PH_SPACE;
            end
        end
        else
        begin
            if (lex_ph != PH_FIELD)
            begin
                if (fld_cnt < 7)
                    fld_cnt++;
                fld_chars = 0;
                seg_reset();
                if (fld_cnt == 1)
                    macro_live = 4'hF;
                lex_ph = PH_FIELD;
            end
            field_push(c);
        end
        if (!q.final_char)
            return;
        if (lex_ph == PH_FIELD)
            field_close();
        st = expr_finish();
        lex_ph = PH_START;
        expected_q.push_back(snapshot(st, 1, 0));
    endfunction

    // ------------------------------------------------------------------
    // Request driver: changes inputs on the falling edge
    // ------------------------------------------------------------------
    task automatic send_req(cron_req_t q);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.func       <= q.func;
        in_ch.char_code  <= q.char_code;
        in_ch.final_char <= q.final_char;
        in_ch.minute     <= q.minute;
        in_ch.hour       <= q.hour;
        in_ch.day        <= q.day;
        in_ch.month      <= q.month;
        in_ch.weekday    <= q.weekday;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        cron_predict(q);
        @(negedge clk);
    endtask

    task automatic send_char(byte unsigned ch, bit last);
        cron_req_t q;
        q.func = 0; q.char_code = ch; q.final_char = last;
        q.minute = $urandom; q.hour = $urandom; q.day = $urandom;
        q.month = $urandom; q.weekday = $urandom;
        send_req(q);
    endtask

    task automatic send_expr(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_time(bit in_range);
        cron_req_t q;
        q.func = 1; q.final_char = $urandom; q.char_code = $urandom;
        if (in_range)
        begin
            q.minute = $urandom_range(59); q.hour = $urandom_range(23);
            q.day = $urandom_range(31, 1); q.month = $urandom_range(12, 1);
            q.weekday = $urandom_range(6);
        end
        else
        begin
            q.minute = $urandom; q.hour = $urandom; q.day = $urandom;
            q.month = $urandom; q.weekday = $urandom;
        end
        send_req(q);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready stalls, long hold-off, and the result checker
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cron_res_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result, status %0d", out_ch.status);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (out_ch.status !== e.status)
                begin
                    $error("status exp %0d got %0d", e.status, out_ch.status);
                    errors++;
                end
                if (out_ch.parse_done !== e.parse_done)
                begin
                    $error("parse_done exp %0d got %0d", e.parse_done, out_ch.parse_done);
                    errors++;
                end
                if (out_ch.matched !== e.matched)
                begin
                    $error("matched exp %0d got %0d", e.matched, out_ch.matched);
                    errors++;
                end
                if (out_ch.minute_bits !== e.minute_bits)
                begin
                    $error("minute_bits exp %h got %h", e.minute_bits, out_ch.minute_bits);
                    errors++;
                end
                if (out_ch.hour_bits !== e.hour_bits)
                begin
                    $error("hour_bits exp %h got %h", e.hour_bits, out_ch.hour_bits);
                    errors++;
                end
                if (out_ch.day_bits !== e.day_bits)
                begin
                    $error("day_bits exp %h got %h", e.day_bits, out_ch.day_bits);
                    errors++;
                end
                if (out_ch.month_bits !== e.month_bits)
                begin
                    $error("month_bits exp %h got %h", e.month_bits, out_ch.month_bits);
                    errors++;
                end
                if (out_ch.weekday_bits !== e.weekday_bits)
                begin
                    $error("weekday_bits exp %h got %h", e.weekday_bits, out_ch.weekday_bits);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Directed: macros, every error code, number extremes, odd bytes.
    task automatic test_directed();
        send_time(1);                      // before any expression
        send_expr("@hourly");
        send_time(1);
        send_expr("  @DAILY\t");
        send_expr("@weekly");
        send_expr("@Monthly");
        send_expr("@hourly x");            // macro plus a field: too few fields
        send_expr("0 0 * *");              // too few fields
        send_expr("*/15 0-23/6 1,15,31 JAN * 6");   // malformed month
        send_expr("2147483647 * * * *");   // value bounds
        send_expr("2147483648 * * * *");   // overflow, malformed
        send_expr("-2147483648 * * * *");
        send_expr("* */0 * * *");          // step not positive
        send_expr("* */-3 * * *");
        send_expr("5-2 * * * *");          // range reversed
        send_expr("* * 0-5 * *");          // range out of field
        send_expr(",,, * * * 7");          // empty minute set, also weekday
        send_expr("59 23 31 12 6");
        send_time(0);
        send_expr("0/7 ,3, /5 -1 \xff\x80");
        send_expr("1-/2 * * 5/ 3-");
        send_expr("*/1 * 1/40 12 0 extra fields here");
        send_time(1);
        send_time(0);
    endtask

    function automatic string rand_num(int f);
        int pick;
        pick = $urandom_range(19);
        if (pick == 0)
            return $sformatf("%0d", $urandom);
        if (pick == 1)
            return $sformatf("-%0d", $urandom_range(3));
        return $sformatf("%0d", $urandom_range(fld_high(f) + 1, fld_low(f)));
    endfunction

    function automatic string rand_segment(int f);
        case ($urandom_range(6))
            0: return "*";
            1: return rand_num(f);
            2: return {rand_num(f), "-", rand_num(f)};
            3: return {"*/", $sformatf("%0d", $urandom_range(12))};
            4: return {rand_num(f), "/", $sformatf("%0d", $urandom_range(30, 1))};
            5: return {rand_num(f), "-", rand_num(f), "/",
                       $sformatf("%0d", $urandom_range(20))};
            default: return {"/", $sformatf("%0d", $urandom_range(9, 1))};
        endcase
    endfunction

    function automatic string rand_expr();
        string s, sep;
        int    nf;
        // Mostly five well-formed fields; some short, long, noisy or macro.
        if ($urandom_range(19) == 0)
            return macro_str($urandom_range(3));
        nf = ($urandom_range(9) == 0) ? $urandom_range(7, 1) : 5;
        s = ($urandom_range(4) == 0) ? " " : "";
        for (int f = 0; f < nf; f++)
        begin
            if (f > 0)
            begin
                sep = ($urandom_range(3) == 0) ? "\t " : " ";
                s = {s, sep};
            end
            s = {s, rand_segment(f < 5 ? f : 4)};
            if ($urandom_range(3) == 0)
                s = {s, ",", rand_segment(f < 5 ? f : 4)};
        end
        if ($urandom_range(15) == 0)
        begin
            sep = " ";
            sep[0] = $urandom;             // stray byte, any value
            s = {s, sep};
        end
        return s;
    endfunction

    task automatic test_random(int n_req);
        int sent;
        string s;
        sent = 0;
        while (sent < n_req)
        begin
            s = rand_expr();
            send_expr(s);
            sent += s.len();
            repeat ($urandom_range(6, 1))
            begin
                send_time($urandom_range(7) != 0);
                sent++;
            end
        end
    endtask

    // Receiver holds off long while the sender keeps feeding; then the
    // sender pauses until all results are back.
    task automatic test_backpressure();
        hold_off = 400;
        send_expr("*/2 */3 */4 */5 */6");
        repeat (6) send_time(1);
        send_expr("@daily");
        send_time(1);
        wait_drained();
        send_time(1);
    endtask

    initial
    begin
        errors = 0;
        cycle_cnt = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        lex_ph = PH_START;
        expr_begin();
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.func = 1'b0;
        in_ch.char_code = '0;
        in_ch.final_char = 1'b0;
        in_ch.minute = '0;
        in_ch.hour = '0;
        in_ch.day = '0;
        in_ch.month = '0;
        in_ch.weekday = '0;
        out_ch.ready = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(90);
        send_idle_pct = 55;
        test_random(90);
        send_idle_pct = 0;
        recv_stall_pct = 55;
        test_random(90);
        send_idle_pct = 21;
        recv_stall_pct = 21;
        test_random(90);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_backpressure();
        test_random(40);

        wait_drained();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
